### hdl/wrcf_pkg.sv
// Package for the waveform record channel filter.
// Holds the header layout constants and the command type that the front
// parser hands to the back end through the queue.
package wrcf_pkg;

  localparam int unsigned STAMP_BYTES = 8;
  localparam int unsigned MASK_WORD_W = 64;
  localparam int unsigned MASK_WORDS  = 4;

  localparam logic [3:0] CHANNEL_POS     = 4'd8;
  localparam logic [3:0] COUNT_FIRST_POS = 4'd9;
  localparam logic [3:0] GATE_POS        = 4'd13;
  localparam logic [3:0] BURST_LAST_BEAT = 4'd8;

  typedef enum logic {
    CMD_PASS  = 1'b0,
    CMD_BURST = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [63:0] stamp;
    logic [7:0]  data;
    logic        rec_last;
  } cmd_t;

endpackage

### hdl/wrcf_front.sv
// Front parser of the waveform record channel filter.
// Tracks the record header and payload, holds the channel mask and issues
// commands into the queue; depends on wrcf_pkg.
module wrcf_front
  import wrcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        cmd_ready,
  output logic        cmd_valid,
  output cmd_t        cmd
);

  logic [255:0] mask_r;
  logic [63:0]  stamp_r, stamp_nxt;
  logic [3:0]   pos_r, pos_nxt;
  logic [31:0]  sc_r, sc_nxt;
  logic [40:0]  rem_r, rem_nxt;
  logic         sel_r, sel_nxt;
  logic         accept;
  logic         emit;
  logic         rec_last;
  cmd_kind_t    kind;
  logic [8:0]   gate_factor;
  logic [40:0]  payload;

  assign in_tready = cmd_ready;
  assign accept    = in_tvalid && in_tready;

  assign gate_factor = {1'b0, in_tdata} + 9'd2;
  assign payload     = 41'(sc_r) * 41'(gate_factor);

  always_comb begin
    pos_nxt   = pos_r;
    sc_nxt    = sc_r;
    rem_nxt   = rem_r;
    sel_nxt   = sel_r;
    stamp_nxt = stamp_r;
    emit      = 1'b0;
    rec_last  = 1'b0;
    kind      = CMD_PASS;
    if (rem_r != '0) begin
      rem_nxt  = rem_r - 41'd1;
      emit     = sel_r;
      rec_last = (rem_r == 41'd1);
      if (rem_r == 41'd1) begin
        pos_nxt = '0;
        sc_nxt  = '0;
        sel_nxt = 1'b0;
      end
    end else if (pos_r < CHANNEL_POS) begin
      stamp_nxt[{pos_r[2:0], 3'b000} +: 8] = in_tdata;
      pos_nxt = pos_r + 4'd1;
    end else if (pos_r == CHANNEL_POS) begin
      sel_nxt = mask_r[in_tdata];
      emit    = sel_nxt;
      kind    = CMD_BURST;
      pos_nxt = COUNT_FIRST_POS;
    end else if (pos_r < GATE_POS) begin
      case (pos_r)
        COUNT_FIRST_POS: sc_nxt = {24'd0, in_tdata};
        4'd10:           sc_nxt[15:8]  = in_tdata;
        4'd11:           sc_nxt[23:16] = in_tdata;
        default:         sc_nxt[31:24] = in_tdata;
      endcase
      emit    = sel_r;
      pos_nxt = pos_r + 4'd1;
    end else begin
      emit     = sel_r;
      rec_last = (sc_r == '0);
      pos_nxt  = '0;
      if (sc_r == '0) begin
        sc_nxt  = '0;
        sel_nxt = 1'b0;
      end else begin
        rem_nxt = payload;
      end
    end
    if (in_tlast) begin
      rec_last = 1'b1;
      pos_nxt  = '0;
      sc_nxt   = '0;
      rem_nxt  = '0;
      sel_nxt  = 1'b0;
    end
  end

  assign cmd_valid    = accept && emit;
  assign cmd.kind     = kind;
  assign cmd.stamp    = stamp_r;
  assign cmd.data     = in_tdata;
  assign cmd.rec_last = rec_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      pos_r  <= '0;
      sc_r   <= '0;
      rem_r  <= '0;
      sel_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mask_r[{cfg_index, 6'd0} +: MASK_WORD_W] <= cfg_data;
      end
      if (accept) begin
        pos_r <= pos_nxt;
        sc_r  <= sc_nxt;
        rem_r <= rem_nxt;
        sel_r <= sel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stamp_r <= stamp_nxt;
    end
  end

endmodule

### hdl/wrcf_queue.sv
// Command queue between the front parser and the back end.
// A small register-based FIFO of wrcf_pkg::cmd_t entries.
module wrcf_queue
  import wrcf_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic wr_ready,
  output logic rd_valid,
  output cmd_t rd_data,
  input  logic rd_pop
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hdl/wrcf_back.sv
// Back end of the waveform record channel filter.
// Expands queue commands into output beats behind an output register;
// depends on wrcf_pkg.
module wrcf_back
  import wrcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  cmd_t       head,
  output logic       head_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output logic [0:0] out_tuser
);

  logic [3:0] beat_r, beat_nxt;
  logic       valid_r;
  logic [7:0] data_r;
  logic       last_r;
  logic       run_last_r;
  logic       load;
  logic       cmd_done;
  logic [7:0] beat_data;

  assign load     = !valid_r || out_tready;
  assign cmd_done = (head.kind != CMD_BURST) || (beat_r == BURST_LAST_BEAT);
  assign head_pop = head_valid && load && cmd_done;

  always_comb begin
    beat_data = head.data;
    if (head.kind == CMD_BURST && beat_r != BURST_LAST_BEAT) begin
      beat_data = head.stamp[{beat_r[2:0], 3'b000} +: 8];
    end
    beat_nxt = beat_r;
    if (head_valid && load) begin
      beat_nxt = cmd_done ? '0 : beat_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      beat_r <= beat_nxt;
      if (load) begin
        valid_r <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r     <= beat_data;
      last_r     <= cmd_done && head.rec_last;
      run_last_r <= cmd_done;
    end
  end

  assign out_tvalid   = valid_r;
  assign out_tdata    = data_r;
  assign out_tlast    = last_r;
  assign out_tuser[0] = run_last_r;

endmodule

### hdl/waveform_record_channel_filter.sv
// Waveform record channel filter: passes whole records of a selected channel.
// One input byte is accepted per cycle while the command queue has room; a
// selected channel byte expands to 9 output beats, and the queue absorbs the
// difference in rate between the front parser and the back end.
// The first beat of a result passes through the queue and then the output register.
// Synchronous active-low reset clears the parser, the mask and the queue.
module waveform_record_channel_filter
  import wrcf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // message_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // record_last
  output logic [0:0]  out_tuser,  // [0] run_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  logic head_valid, head_pop;
  cmd_t head;

  assign cfg_ready = 1'b1;

  wrcf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_ready (cmd_ready),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  wrcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cmd_valid),
    .wr_data  (cmd),
    .wr_ready (cmd_ready),
    .rd_valid (head_valid),
    .rd_data  (head),
    .rd_pop   (head_pop)
  );

  wrcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### hdl/wrcf_checker.sv
// Port-level checks for the waveform record channel filter.
// Bound to the top level; depends only on its ports.
module wrcf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [0:0] out_tuser
);

  // A stalled beat stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // The end of a record is always the last beat caused by its input byte.
  a_rec_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("record end without run end");

  // The beats of a header burst follow each other without a gap.
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tuser[0] |=> out_tvalid)
    else $error("gap inside a header burst");

  // No beat is shown in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind waveform_record_channel_filter wrcf_checker u_wrcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

### sim/wrcf_record_check.sv
// Checker for the waveform record channel filter: watches the input, output and
// mask write channels, predicts the passed bytes and compares them beat by beat.
// Depends on wrcf_pkg for the header layout constants.
module wrcf_record_check
  import wrcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // message_last
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] out_byte
  input  logic        out_tlast,  // record_last
  input  logic [0:0]  out_tuser,  // [0] run_last
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          bytes_passed
);

  typedef struct packed {
    logic [7:0] data;
    logic       rec_last;
    logic       run_last;
  } beat_t;

  beat_t       passed_bytes_q[$];
  logic [63:0] sel_mask [MASK_WORDS];
  logic [7:0]  stamp [STAMP_BYTES];
  logic [3:0]  hdr_pos;
  logic [31:0] samples;
  logic [7:0]  gates;
  logic [40:0] remaining;
  logic        selected;

  task automatic clear_parser();
    hdr_pos   = '0;
    samples   = '0;
    gates     = '0;
    remaining = '0;
    selected  = 1'b0;
  endtask

  // Advances the parser by one byte and queues the bytes it lets through.
  task automatic filter_byte(input logic [7:0] b, input logic msg_last);
    beat_t       burst [STAMP_BYTES + 1];
    int          n;
    logic [40:0] payload;
    n = 0;
    if (remaining != 0) begin
      remaining = remaining - 1'b1;
      if (selected) begin
        burst[n] = '{b, remaining == 0, 1'b0};
        n++;
      end
      if (remaining == 0) clear_parser();
    end else if (hdr_pos < CHANNEL_POS) begin
      stamp[hdr_pos[2:0]] = b;
      hdr_pos = hdr_pos + 1'b1;
    end else if (hdr_pos == CHANNEL_POS) begin
      selected = sel_mask[b[7:6]][b[5:0]];
      if (selected) begin
        for (int i = 0; i < STAMP_BYTES; i++) begin
          burst[n] = '{stamp[i], 1'b0, 1'b0};
          n++;
        end
        burst[n] = '{b, 1'b0, 1'b0};
        n++;
      end
      hdr_pos = COUNT_FIRST_POS;
    end else if (hdr_pos < GATE_POS) begin
      if (hdr_pos == COUNT_FIRST_POS) samples = '0;
      samples = samples | (32'(b) << (8 * (hdr_pos - COUNT_FIRST_POS)));
      if (selected) begin
        burst[n] = '{b, 1'b0, 1'b0};
        n++;
      end
      hdr_pos = hdr_pos + 1'b1;
    end else begin
      gates   = b;
      payload = 41'(samples) * (41'(b) + 41'd2);
      if (selected) begin
        burst[n] = '{b, payload == 0, 1'b0};
        n++;
      end
      if (payload == 0) begin
        clear_parser();
      end else begin
        remaining = payload;
        hdr_pos   = '0;
      end
    end
    if (msg_last) begin
      if (n > 0) burst[n - 1].rec_last = 1'b1;
      clear_parser();
    end
    if (n > 0) burst[n - 1].run_last = 1'b1;
    for (int i = 0; i < n; i++) passed_bytes_q.push_back(burst[i]);
  endtask

  always @(posedge clk) begin
    beat_t want;
    if (!rst_n) begin
      passed_bytes_q.delete();
      for (int i = 0; i < MASK_WORDS; i++) sel_mask[i] = '0;
      for (int i = 0; i < STAMP_BYTES; i++) stamp[i] = '0;
      clear_parser();
      mismatches   = 0;
      bytes_passed = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        bytes_passed++;
        if (passed_bytes_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output beat: data %02h record_last %0b run_last %0b",
                     out_tdata, out_tlast, out_tuser[0]);
        end else begin
          want = passed_bytes_q.pop_front();
          if (want.data !== out_tdata || want.rec_last !== out_tlast ||
              want.run_last !== out_tuser[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d: expected data %02h rl %0b ul %0b, got data %02h rl %0b ul %0b",
                       bytes_passed, want.data, want.rec_last, want.run_last,
                       out_tdata, out_tlast, out_tuser[0]);
          end
        end
      end
      if (cfg_valid && cfg_ready) sel_mask[cfg_index] = cfg_data;
      if (in_tvalid && in_tready) filter_byte(in_tdata, in_tlast);
    end
    outstanding <= passed_bytes_q.size();
  end

endmodule

### sim/waveform_record_channel_filter_tb.sv
// Testbench top for the waveform record channel filter: drives record streams
// and channel masks, stalls the output side, and reports the verdict.
// Depends on wrcf_pkg, the filter RTL and the wrcf_record_check module.
module waveform_record_channel_filter_tb;
  import wrcf_pkg::*;

  localparam int HEADER_BYTES  = 14;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 80;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_BYTES   = 20;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [63:0] cfg_data   = '0;
  int          mismatches;
  int          outstanding;
  int          bytes_passed;

  logic steady     = 1'b0;
  logic hold_token = 1'b0;
  logic hold_seen;
  int   hold_left;
  int   stall_cycles;
  int   bytes_sent   = 0;
  int   records_sent = 0;
  int   mask_loads   = 0;

  always #5 clk = ~clk;

  waveform_record_channel_filter dut (.*);

  wrcf_record_check record_check (.*);

  // Output side: random back-pressure, plus one long hold on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_seen  <= 1'b0;
      hold_left  <= 0;
    end else if (hold_seen != hold_token) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic l);
    while (!steady && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  // Sends one record; a cut at byte k ends the message there instead.
  task automatic send_record(input logic [63:0] ts, input logic [7:0] ch,
                             input logic [31:0] s, input logic [7:0] g,
                             input int cut, input logic end_msg);
    longint     len;
    logic [7:0] b;
    logic       l;
    len = HEADER_BYTES + longint'(s) * (longint'(g) + 2);
    records_sent++;
    for (longint i = 0; i < len; i++) begin
      if (i < STAMP_BYTES) b = ts[8*i +: 8];
      else if (i == CHANNEL_POS) b = ch;
      else if (i < GATE_POS) b = s[8*(i - COUNT_FIRST_POS) +: 8];
      else if (i == GATE_POS) b = g;
      else b = 8'($urandom_range(0, 255));
      l = (i == cut) || (end_msg && i == len - 1);
      push_byte(b, l);
      if (i == cut) break;
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_masks(input logic [255:0] bits);
    for (int i = 0; i < MASK_WORDS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= bits[64*i +: 64];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    mask_loads++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_records(input int n_bytes);
    int start;
    int r;
    int k;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_record(rand64(), 8'($urandom_range(0, 255)), $urandom_range(0, 3),
                    8'($urandom_range(0, 3)), -1, 1'($urandom_range(1)));
      end else if (r < 80) begin
        send_record(rand64(), 8'($urandom_range(0, 255)), $urandom, 8'($urandom),
                    $urandom_range(HEADER_BYTES, HEADER_BYTES + 10), 1'b0);
      end else if (r < 90) begin
        send_record(rand64(), 8'($urandom_range(0, 255)), $urandom_range(0, 3),
                    8'($urandom_range(0, 3)), $urandom_range(0, HEADER_BYTES - 1), 1'b0);
      end else begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++)
          push_byte(8'($urandom_range(0, 255)), (i == k - 1) || ($urandom_range(99) < 30));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed records with every channel selected, with a long output hold
    // while input keeps coming.
    load_masks({256{1'b1}});
    hold_token <= ~hold_token;
    send_record(64'hFF00_FF00_00FF_00FF, 8'hFF, 32'd0, 8'd0, -1, 1'b0);
    send_record(rand64(), 8'h00, 32'd1, 8'd0, 3, 1'b0);
    send_record(rand64(), 8'h00, 32'hFFFF_FFFF, 8'hFF, HEADER_BYTES, 1'b0);
    send_record(rand64(), 8'h80, 32'd1, 8'd1, CHANNEL_POS, 1'b0);
    settle();

    // Random masks.
    load_masks({rand64(), rand64(), rand64(), rand64()});
    random_records(PHASE_BYTES);
    settle();

    // Alternate mask words fully open and fully closed, without idling.
    load_masks({{64{1'b1}}, 64'd0, {64{1'b1}}, 64'd0});
    steady <= 1'b1;
    random_records(PHASE_BYTES);
    settle();

    // Sparse masks with random idling again.
    steady <= 1'b0;
    load_masks({rand64() & rand64() & rand64(), rand64() & rand64() & rand64(),
                rand64() & rand64() & rand64(), rand64() & rand64() & rand64()});
    random_records(PHASE_BYTES);
    settle();

    $display("Run covered %0d input beats in %0d records under %0d mask settings, %0d beats out.",
             bytes_sent, records_sent, mask_loads, bytes_passed);
    $display("It included empty payloads, message ends in header, burst and payload, and stalls.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/wrcf_pkg.sv
hdl/wrcf_front.sv
hdl/wrcf_queue.sv
hdl/wrcf_back.sv
hdl/waveform_record_channel_filter.sv
hdl/wrcf_checker.sv
sim/wrcf_record_check.sv
sim/waveform_record_channel_filter_tb.sv
